@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the victim selector.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PVS_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`define PVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PVS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PVS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/pvs_pkg.sv @@
// Constants for the page replacement victim selector: command, policy and
// register codes, field widths and reset values. No dependencies.
package pvs_pkg;
	localparam logic [1:0] CMD_ACCESS  = 2'd0;
	localparam logic [1:0] CMD_INSTALL = 2'd1;
	localparam logic [1:0] CMD_SELECT  = 2'd2;

	localparam logic [2:0] POL_FIFO   = 3'd0;
	localparam logic [2:0] POL_RANDOM = 3'd1;
	localparam logic [2:0] POL_CLOCK  = 3'd2;
	localparam logic [2:0] POL_NRU    = 3'd3;
	localparam logic [2:0] POL_AGING  = 3'd4;
	localparam logic [2:0] POL_WSET   = 3'd5;

	localparam logic [1:0] CFG_POLICY = 2'd0;
	localparam logic [1:0] CFG_FRAMES = 2'd1;
	localparam logic [1:0] CFG_WINDOW = 2'd2;

	localparam int IDX_W = 7;
	localparam int NOW_W = 32;
	localparam int RND_W = 31;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 8;

	localparam logic [7:0]  FRAMES_RST = 8'd4;
	localparam logic [31:0] WINDOW_RST = 32'd50;
endpackage

@@ hw/rtl/page_replacement_victim_selector.sv @@
// Page replacement victim selector, top level.
// Uses pvs_pkg, pvs_mem (frame state memory), pvs_mod (serial remainder).
//
// Usage:
//  - Commands arrive on the s_ stream (tuser = command). Access and install
//    update one frame and give no result; select gives one transaction on
//    the m_ stream with the victim frame and its modified bit.
//  - Registers are written on the cfg_ channel (always ready), only while
//    the block is idle; this binds the user, the block does not enforce it.
//  - One command at a time. Access/install: read the frame, then write it
//    back. Select: the serial remainder (hand or random value modulo n),
//    then the memory read/write-back loop once per scanned frame (up to n
//    frames, clock up to n+1; NRU adds an end step, plus the referenced-bit
//    clear pass over n frames when it is due), then the victim is fetched
//    and registered.
//  - Reset clears the frame state through per-entry valid bits at once;
//    no clearing pass, the block is ready straight out of reset.
//  - A result waits in the output register while the receiver stalls;
//    access and install transactions still go on behind it, a further
//    select waits for the register to empty before it completes.
module page_replacement_victim_selector
	import pvs_pkg::*;
#(
	parameter int MAX_FRAME_COUNT = 128,
	parameter int AGE_WIDTH       = 32,
	parameter int TIME_WIDTH      = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [6:0] frame_index, [7] set_modified, [39:8] now_tick,
	// [70:40] random_value, [71] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] command
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [6:0] victim_frame, [7] victim_modified
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	localparam int AW = $clog2(MAX_FRAME_COUNT);
	localparam int NW = $clog2(MAX_FRAME_COUNT + 1);
	localparam int WW = 2 + AGE_WIDTH + TIME_WIDTH;
	localparam int AGE_LSB  = 2;
	localparam int LAST_LSB = 2 + AGE_WIDTH;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_CMD_RD   = 4'd1;
	localparam logic [3:0] ST_CMD_WR   = 4'd2;
	localparam logic [3:0] ST_MOD_WAIT = 4'd3;
	localparam logic [3:0] ST_SCAN_RD  = 4'd4;
	localparam logic [3:0] ST_SCAN_EV  = 4'd5;
	localparam logic [3:0] ST_NRU_END  = 4'd6;
	localparam logic [3:0] ST_CLR_RD   = 4'd7;
	localparam logic [3:0] ST_CLR_WR   = 4'd8;
	localparam logic [3:0] ST_V_RD     = 4'd9;
	localparam logic [3:0] ST_V_DATA   = 4'd10;
	localparam logic [3:0] ST_FIN      = 4'd11;

	// configuration
	logic [2:0]  policy_q;
	logic [7:0]  frames_q;
	logic [31:0] window_q;

	// control and per-command state
	logic [3:0]            state_q;
	logic [AW-1:0]         hand_q;
	logic [TIME_WIDTH-1:0] lrr_q;
	logic [1:0]            cmd_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  wr_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [AW-1:0]         p_q;
	logic [NW-1:0]         cnt_q;
	logic [AW-1:0]         v_q;
	logic [AGE_WIDTH-1:0]  minage_q;
	logic [TIME_WIDTH-1:0] oldest_q;
	logic [3:0]            found_q;
	logic [AW-1:0]         first_q [4];
	logic                  vmod_q;
	logic                  out_vld_q;
	logic [IDX_W-1:0]      out_frame_q;
	logic                  out_mod_q;

	// memory ports
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [WW-1:0] rd_data, wr_data;

	// remainder unit
	logic             mod_start, mod_done;
	logic [RND_W-1:0] mod_dividend;
	logic [AW-1:0]    mod_rem;

	logic [NW-1:0]         n_w;
	logic                  s_acc;
	logic                  idx_ok;
	logic                  d_ref, d_mod;
	logic [AGE_WIDTH-1:0]  d_age, age_new;
	logic [TIME_WIDTH-1:0] d_last;
	logic                  ws_old, clr_due, cnt_last;
	logic [1:0]            cls;
	logic [AW-1:0]         ev_v, nru_v;
	logic                  ev_end;
	logic                  out_load;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] x, input logic [NW-1:0] nn);
		logic [31:0] inc;
		inc = 32'(x) + 32'd1;
		nxt = (inc == 32'(nn)) ? '0 : AW'(inc);
	endfunction

	// effective frame count: 0 acts as 1, above the maximum clamps
	always_comb begin
		if (frames_q == '0) begin
			n_w = NW'(1);
		end else if (32'(frames_q) > 32'(MAX_FRAME_COUNT)) begin
			n_w = NW'(MAX_FRAME_COUNT);
		end else begin
			n_w = NW'(frames_q);
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign idx_ok    = 32'(s_tdata[IDX_W-1:0]) < 32'(MAX_FRAME_COUNT);

	assign mod_start    = s_acc && (s_tuser == CMD_SELECT);
	assign mod_dividend = (policy_q == POL_RANDOM) ? s_tdata[40 +: RND_W] : RND_W'(hand_q);

	// fields of the word read back
	assign d_ref   = rd_data[0];
	assign d_mod   = rd_data[1];
	assign d_age   = rd_data[AGE_LSB +: AGE_WIDTH];
	assign d_last  = rd_data[LAST_LSB +: TIME_WIDTH];
	assign age_new = (d_age >> 1) | {d_ref, {(AGE_WIDTH-1){1'b0}}};
	assign ws_old  = 64'(TIME_WIDTH'(now_q - d_last)) >= 64'(window_q);
	assign clr_due = 64'(TIME_WIDTH'(now_q - lrr_q)) >= 64'(window_q);
	assign cnt_last = (32'(cnt_q) + 32'd1) == 32'(n_w);
	assign cls     = {d_ref, d_mod};

	// scan step: victim candidate and end of scan
	always_comb begin
		ev_v   = v_q;
		ev_end = cnt_last;
		case (policy_q)
			POL_CLOCK: begin
				ev_v   = p_q;
				ev_end = !d_ref;
			end
			POL_NRU: begin
				ev_end = cnt_last || (cls == 2'd0);
			end
			POL_AGING: begin
				if (age_new < minage_q) begin
					ev_v = p_q;
				end
			end
			POL_WSET: begin
				if (!d_ref && ws_old) begin
					ev_v   = p_q;
					ev_end = 1'b1;
				end else if (!d_ref && d_last < oldest_q) begin
					ev_v = p_q;
				end
			end
			default: begin
				ev_end = cnt_last;
			end
		endcase
	end

	// lowest non-empty NRU class
	always_comb begin
		nru_v = v_q;
		for (int c = 3; c >= 0; c--) begin
			if (found_q[c]) begin
				nru_v = first_q[c];
			end
		end
	end

	// memory access per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = p_q;
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = rd_data;
		case (state_q)
			ST_CMD_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(idx_q);
			end
			ST_CMD_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q);
				if (cmd_q == CMD_ACCESS) begin
					wr_data[0] = 1'b1;
					wr_data[1] = d_mod | wr_q;
				end else begin
					wr_data[1] = 1'b0;
					wr_data[AGE_LSB +: AGE_WIDTH]   = '0;
					wr_data[LAST_LSB +: TIME_WIDTH] = now_q;
				end
			end
			ST_SCAN_RD, ST_CLR_RD: begin
				rd_en = 1'b1;
			end
			ST_SCAN_EV: begin
				wr_data[0] = 1'b0;
				case (policy_q)
					POL_CLOCK: wr_en = d_ref;
					POL_AGING: begin
						wr_en = 1'b1;
						wr_data[AGE_LSB +: AGE_WIDTH] = age_new;
					end
					POL_WSET: begin
						wr_en = d_ref;
						wr_data[LAST_LSB +: TIME_WIDTH] = now_q;
					end
					default: wr_en = 1'b0;
				endcase
			end
			ST_CLR_WR: begin
				wr_en      = 1'b1;
				wr_data[0] = 1'b0;
			end
			ST_V_RD: begin
				rd_en   = 1'b1;
				rd_addr = v_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign out_load = (state_q == ST_FIN) && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			frames_q <= FRAMES_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POLICY: policy_q <= cfg_data[2:0];
				CFG_FRAMES: frames_q <= cfg_data[7:0];
				CFG_WINDOW: window_q <= cfg_data;
				default: policy_q <= policy_q;
			endcase
		end
	end

	// payload of the command and scan bookkeeping
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q <= s_tuser;
			idx_q <= s_tdata[IDX_W-1:0];
			wr_q  <= s_tdata[7];
			now_q <= TIME_WIDTH'(s_tdata[8 +: NOW_W]);
		end
		case (state_q)
			ST_MOD_WAIT: begin
				p_q      <= mod_rem;
				v_q      <= mod_rem;
				cnt_q    <= '0;
				found_q  <= '0;
				minage_q <= '1;
				oldest_q <= '1;
			end
			ST_SCAN_EV: begin
				v_q <= ev_v;
				if (policy_q == POL_AGING && age_new < minage_q) begin
					minage_q <= age_new;
				end
				if (policy_q == POL_WSET && !d_ref && d_last < oldest_q) begin
					oldest_q <= d_last;
				end
				if (policy_q == POL_NRU && !found_q[cls]) begin
					found_q[cls] <= 1'b1;
					first_q[cls] <= p_q;
				end
				if (!ev_end) begin
					p_q   <= nxt(p_q, n_w);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_NRU_END: begin
				v_q <= nru_v;
				p_q <= '0;
			end
			ST_CLR_WR: begin
				p_q <= nxt(p_q, n_w);
			end
			ST_V_DATA: begin
				vmod_q <= d_mod;
			end
			default: begin
				vmod_q <= vmod_q;
			end
		endcase
		if (out_load) begin
			out_frame_q <= IDX_W'(v_q);
			out_mod_q   <= vmod_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hand_q    <= '0;
			lrr_q     <= '1;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == CMD_SELECT) begin
							state_q <= ST_MOD_WAIT;
						end else if ((s_tuser == CMD_ACCESS || s_tuser == CMD_INSTALL)
								&& idx_ok) begin
							state_q <= ST_CMD_RD;
						end
					end
				end
				ST_CMD_RD: state_q <= ST_CMD_WR;
				ST_CMD_WR: state_q <= ST_IDLE;
				ST_MOD_WAIT: begin
					if (mod_done) begin
						case (policy_q)
							POL_RANDOM: begin
								hand_q  <= mod_rem;
								state_q <= ST_V_RD;
							end
							POL_CLOCK, POL_NRU, POL_AGING, POL_WSET: begin
								state_q <= ST_SCAN_RD;
							end
							default: begin
								hand_q  <= nxt(mod_rem, n_w);
								state_q <= ST_V_RD;
							end
						endcase
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_EV;
				ST_SCAN_EV: begin
					if (!ev_end) begin
						state_q <= ST_SCAN_RD;
					end else if (policy_q == POL_NRU) begin
						state_q <= ST_NRU_END;
					end else begin
						hand_q  <= nxt(ev_v, n_w);
						state_q <= ST_V_RD;
					end
				end
				ST_NRU_END: begin
					hand_q <= nxt(nru_v, n_w);
					if (clr_due) begin
						lrr_q   <= now_q;
						state_q <= ST_CLR_RD;
					end else begin
						state_q <= ST_V_RD;
					end
				end
				ST_CLR_RD: state_q <= ST_CLR_WR;
				ST_CLR_WR: begin
					if ((32'(p_q) + 32'd1) == 32'(n_w)) begin
						state_q <= ST_V_RD;
					end else begin
						state_q <= ST_CLR_RD;
					end
				end
				ST_V_RD:   state_q <= ST_V_DATA;
				ST_V_DATA: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_mod_q, out_frame_q};

	pvs_mem #(
		.DEPTH (MAX_FRAME_COUNT),
		.WIDTH (WW),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pvs_mod #(
		.DW (RND_W),
		.NW (NW),
		.AW (AW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (n_w),
		.done     (mod_done),
		.rem      (mod_rem)
	);

`include "assert_macros.svh"
	// read-then-write loop never touches one entry with both ports at once
	`PVS_ASSERT_IMP(a_no_rw_clash, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)
	// remainder is a valid frame of the current count
	`PVS_ASSERT_IMP(a_rem_range, clk, arst_n, mod_done, 32'(mod_rem) < 32'(n_w))
	// every scan read is followed directly by its evaluation
	`PVS_ASSERT_NEXT(a_scan_order, clk, arst_n, state_q == ST_SCAN_RD, state_q == ST_SCAN_EV)
	// scan pointer stays inside the frame range in every scan evaluation
	`PVS_ASSERT_IMP(a_scan_ptr, clk, arst_n, state_q == ST_SCAN_EV, 32'(p_q) < 32'(n_w))
endmodule

@@ hw/rtl/pvs_mem.sv @@
// Frame state memory: one write port, one registered read port, per-entry
// valid bits so unwritten entries read as zero. No dependencies.
module pvs_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 66,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] data_s1;
	logic             vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = vld_s1 ? data_s1 : '0;
endmodule

@@ hw/rtl/pvs_mod.sv @@
// Serial remainder unit, one quotient bit per cycle (restoring).
// No dependencies.
module pvs_mod #(
	parameter int DW = 31,
	parameter int NW = 8,
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [AW-1:0] rem
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] div_q;
	logic [NW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], 1'b0};
			rem_q <= fits ? NW'(trial - {1'b0, div_q}) : NW'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = AW'(rem_q);
endmodule
